FILE: sv/era_pkg.sv
// Shared types and codes for the extended rational ALU.
package era_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_REM = 3'd4,
    OP_CMP = 3'd5,
    OP_NEG = 3'd6,
    OP_INV = 3'd7
  } op_t;

  localparam logic [1:0] ORD_LT    = 2'd0;
  localparam logic [1:0] ORD_EQ    = 2'd1;
  localparam logic [1:0] ORD_GT    = 2'd2;
  localparam logic [1:0] ORD_UNORD = 2'd3;

  typedef enum logic {
    MDU_MUL = 1'b0,
    MDU_DIV = 1'b1
  } mdu_mode_t;

  typedef struct packed {
    logic      start;
    mdu_mode_t mode;
  } mdu_ctl_t;

  typedef enum logic [1:0] {
    SEL_A = 2'd0,
    SEL_B = 2'd1,
    SEL_R = 2'd2
  } mk_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MK_CHK,
    ST_GCD,
    ST_GCD_W,
    ST_QUO,
    ST_QUO_W,
    ST_MK_END,
    ST_B_XF,
    ST_DISP,
    ST_MUL,
    ST_MUL_W,
    ST_COMB,
    ST_REM_W,
    ST_DONE
  } state_t;

endpackage

FILE: sv/extended_rational_alu.sv
// Extended rational ALU top level: sequencer around one shared multiply/divide unit.
//
// Usage: drive op and both operands (num, den, eps) and raise start while busy
// is low; that edge accepts the beat. busy stays high until the result has
// been shown. The result beat is on r_num, r_den, r_eps, order, equal, error
// and overflow for exactly one cycle, marked by valid; the receiver cannot
// stall, so it must take the beat in that cycle.
// Flow: normalize a, normalize b (each a gcd reduction if finite and nonzero),
// special-value dispatch, up to three products, for remainder a divide, then a
// reduction of the result (none for compare).
// Cost: the gcd runs Euclid steps, each a full divide, so the cost depends
// on the data: each reduction of a finite nonzero value (a, b, result) takes
// its Euclid steps plus two quotient divides, the products add three
// multiplies and remainder one more divide. A special value skips the products
// and the result reduction; only when both operands are zero, infinite or
// ambiguous does a beat leave the unit unused; one beat is in flight at a time.
// Reset: synchronous rst returns the sequencer to idle and drops busy and
// valid; any beat in flight is lost.
module extended_rational_alu import era_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         op,
  input  logic signed [63:0] a_num,
  input  logic signed [63:0] a_den,
  input  logic signed [1:0]  a_eps,
  input  logic signed [63:0] b_num,
  input  logic signed [63:0] b_den,
  input  logic signed [1:0]  b_eps,
  output logic               valid,
  output logic signed [63:0] r_num,
  output logic [62:0]        r_den,
  output logic signed [1:0]  r_eps,
  output logic [1:0]         order,
  output logic               equal,
  output logic               error,
  output logic               overflow
);

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * WORD_BITS;
  localparam logic [PW-1:0] LIM = PW'(1) << (W - 1);

  // neg flag, magnitudes and epsilon sign of one extended rational
  typedef struct packed {
    logic              neg;
    logic [PW-1:0]     n;
    logic [PW-1:0]     d;
    logic signed [1:0] eps;
  } xval_t;

  localparam logic signed [1:0] S_POS  = 2'sb01;
  localparam logic signed [1:0] S_ZERO = 2'sb00;
  localparam logic signed [1:0] S_NEG  = 2'sb11;

  function automatic xval_t norm_in(input logic [63:0] num, input logic [63:0] den,
                                    input logic [1:0] e);
    logic [W-1:0] xv;
    logic [W-1:0] yv;
    xval_t        o;
    xv    = num[W-1:0];
    yv    = den[W-1:0];
    o.n   = PW'(xv[W-1] ? W'(-xv) : xv);
    o.d   = PW'(yv[W-1] ? W'(-yv) : yv);
    o.neg = xv[W-1] ^ ((yv != '0) && yv[W-1]);
    o.eps = (e == 2'b01) ? S_POS : ((e == 2'b00) ? S_ZERO : S_NEG);
    return o;
  endfunction

  function automatic logic is_zr(input xval_t v);
    return v.n == '0;
  endfunction
  function automatic logic is_inf(input xval_t v);
    return v.d == '0;
  endfunction
  function automatic logic is_amb(input xval_t v);
    return (v.n == '0) && (v.d == '0);
  endfunction
  function automatic logic signed [1:0] sgn(input xval_t v);
    return (v.n == '0) ? v.eps : (v.neg ? S_NEG : S_POS);
  endfunction
  function automatic xval_t v_amb();
    xval_t o;
    o = '0;
    return o;
  endfunction
  function automatic xval_t v_inf(input logic signed [1:0] s);
    xval_t o;
    o     = '0;
    o.neg = (s == S_NEG);
    o.n   = PW'(1);
    return o;
  endfunction
  function automatic xval_t v_zero(input logic signed [1:0] e);
    xval_t o;
    o     = '0;
    o.d   = PW'(1);
    o.eps = e;
    return o;
  endfunction
  function automatic xval_t v_neg(input xval_t v);
    xval_t o;
    o = v;
    if (!is_amb(v)) begin
      if (is_zr(v)) o.eps = -v.eps;
      else o.neg = !v.neg;
    end
    return o;
  endfunction
  function automatic xval_t v_inv(input xval_t v);
    xval_t o;
    o = v;
    if (is_amb(v)) o = v_amb();
    else if (is_zr(v)) o = (v.eps == S_ZERO) ? v_amb() : v_inf(v.eps);
    else if (is_inf(v)) o = v_zero(sgn(v));
    else begin
      // reduced values are coprime, so a swap stays reduced
      o.n = v.d;
      o.d = v.n;
    end
    return o;
  endfunction

  state_t            state, state_next;
  mk_sel_t           sel;
  op_t               op_q;
  xval_t             a_v, b_v, mk_v, r_v;
  logic [PW-1:0]     g_x, g_y;
  logic [PW-1:0]     t1, t2, t3;
  logic [1:0]        mul_idx;
  logic              quo_idx;
  logic [1:0]        res_ord;
  logic              res_eq, res_err;

  mdu_ctl_t          mctl;
  logic [PW-1:0]     mx, my, mquo, mrem;
  logic              mdone;

  era_mdu #(.PW(PW)) u_mdu (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mctl),
    .x    (mx),
    .y    (my),
    .done (mdone),
    .quo  (mquo),
    .rem  (mrem)
  );

  // operation classes
  logic cls_add, cls_mul;
  assign cls_add = (op_q == OP_ADD) || (op_q == OP_SUB);
  assign cls_mul = (op_q == OP_MUL) || (op_q == OP_DIV);

  // special-value dispatch on reduced a and (transformed) b
  logic              sp_hit, sp_err, sp_eq;
  xval_t             sp_val;
  logic [1:0]        sp_ord;
  logic signed [1:0] sa, sb;

  assign sa = sgn(a_v);
  assign sb = sgn(b_v);

  always_comb begin
    sp_hit = 1'b0;
    sp_err = 1'b0;
    sp_val = v_amb();
    sp_ord = ORD_LT;
    if (is_inf(a_v) || is_inf(b_v)) sp_eq = 1'b0;
    else if (is_zr(a_v) && is_zr(b_v)) sp_eq = (a_v.eps == S_ZERO) && (b_v.eps == S_ZERO);
    else sp_eq = (a_v.neg == b_v.neg) && (a_v.n == b_v.n) && (a_v.d == b_v.d);
    case (op_q)
      OP_ADD, OP_SUB: begin
        sp_hit = 1'b1;
        if (is_amb(a_v) || is_amb(b_v)) sp_val = v_amb();
        else if (is_inf(a_v) && is_inf(b_v)) sp_val = (sa != sb) ? v_amb() : v_inf(sa);
        else if (is_inf(a_v)) sp_val = a_v;
        else if (is_inf(b_v)) sp_val = b_v;
        else if (is_zr(a_v) && is_zr(b_v)) begin
          if (a_v.eps == b_v.eps || b_v.eps == S_ZERO) sp_val = a_v;
          else if (a_v.eps == S_ZERO) sp_val = b_v;
          else sp_val = v_amb();
        end else sp_hit = 1'b0;
      end
      OP_MUL, OP_DIV: begin
        sp_hit = 1'b1;
        if (is_amb(a_v) || is_amb(b_v)) sp_val = v_amb();
        else if (is_inf(a_v) || is_inf(b_v)) begin
          if (!is_zr(a_v) && !is_zr(b_v)) sp_val = v_inf((sa == sb) ? S_POS : S_NEG);
          else if (sa == S_ZERO || sb == S_ZERO) sp_val = v_zero(S_ZERO);
          else sp_val = v_amb();
        end else if (is_zr(a_v) || is_zr(b_v)) begin
          if (sa == S_ZERO || sb == S_ZERO) sp_val = v_zero(S_ZERO);
          else sp_val = v_zero((sa == sb) ? S_POS : S_NEG);
        end else sp_hit = 1'b0;
      end
      OP_REM: begin
        sp_hit = 1'b1;
        if (is_inf(a_v) || is_inf(b_v) || is_zr(b_v)) begin
          sp_err = 1'b1;
          sp_val = v_amb();
        end else if (is_zr(a_v)) sp_val = a_v;
        else sp_hit = 1'b0;
      end
      OP_CMP: begin
        sp_hit = 1'b1;
        if (is_amb(a_v) || is_amb(b_v)) sp_ord = ORD_UNORD;
        else if (sa != sb) sp_ord = (sa < sb) ? ORD_LT : ORD_GT;
        else if (is_zr(a_v) || is_zr(b_v)) begin
          if (sa == S_ZERO && sb == S_ZERO) sp_ord = ORD_EQ;
          else if (is_zr(a_v) && is_zr(b_v)) sp_ord = ORD_EQ;
          else if (is_zr(a_v)) sp_ord = (sb == S_NEG) ? ORD_GT : ORD_LT;
          else sp_ord = (sa == S_NEG) ? ORD_LT : ORD_GT;
        end else if (is_inf(a_v) && is_inf(b_v)) sp_ord = ORD_EQ;
        else if (is_inf(a_v)) sp_ord = (sa == S_NEG) ? ORD_LT : ORD_GT;
        else if (is_inf(b_v)) sp_ord = (sb == S_NEG) ? ORD_GT : ORD_LT;
        else sp_hit = 1'b0;
      end
      OP_NEG: begin
        sp_hit = 1'b1;
        sp_val = v_neg(a_v);
      end
      OP_INV: begin
        sp_hit = 1'b1;
        sp_val = v_inv(a_v);
      end
      default: sp_hit = 1'b1;
    endcase
  end

  // combine step after the products
  logic [PW-1:0] sum_n;
  logic          sum_neg;
  logic          t_lt, t_gt;
  logic [1:0]    cmp_ord;

  assign t_lt = t1 < t2;
  assign t_gt = t1 > t2;

  always_comb begin
    if (a_v.neg == b_v.neg) begin
      sum_n   = t1 + t2;
      sum_neg = a_v.neg;
    end else if (!t_lt) begin
      sum_n   = t1 - t2;
      sum_neg = a_v.neg;
    end else begin
      sum_n   = t2 - t1;
      sum_neg = b_v.neg;
    end
    // a negative common sign flips the magnitude order
    if (sa == S_NEG) cmp_ord = t_gt ? ORD_LT : (t_lt ? ORD_GT : ORD_EQ);
    else cmp_ord = t_lt ? ORD_LT : (t_gt ? ORD_GT : ORD_EQ);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_MK_CHK;
      ST_MK_CHK: state_next = (is_zr(mk_v) || is_inf(mk_v)) ? ST_MK_END : ST_GCD;
      ST_GCD:    state_next = (g_y == '0) ? ST_QUO : ST_GCD_W;
      ST_GCD_W:  if (mdone) state_next = ST_GCD;
      ST_QUO:    state_next = ST_QUO_W;
      ST_QUO_W:  if (mdone) state_next = quo_idx ? ST_MK_END : ST_QUO;
      ST_MK_END: begin
        case (sel)
          SEL_A:   state_next = ST_MK_CHK;
          SEL_B:   state_next = ST_B_XF;
          default: state_next = ST_DONE;
        endcase
      end
      ST_B_XF:   state_next = ST_DISP;
      ST_DISP:   state_next = sp_hit ? ST_DONE : ST_MUL;
      ST_MUL:    state_next = ST_MUL_W;
      ST_MUL_W:  if (mdone) state_next = (mul_idx == 2'd2) ? ST_COMB : ST_MUL;
      ST_COMB: begin
        if (op_q == OP_REM) state_next = ST_REM_W;
        else if (op_q == OP_CMP) state_next = ST_DONE;
        else state_next = ST_MK_CHK;
      end
      ST_REM_W:  if (mdone) state_next = ST_MK_CHK;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // shared unit commands
  always_comb begin
    mctl.start = 1'b0;
    mctl.mode  = MDU_DIV;
    mx         = g_x;
    my         = g_y;
    case (state)
      ST_GCD: mctl.start = (g_y != '0);
      ST_QUO: begin
        mctl.start = 1'b1;
        mx         = quo_idx ? mk_v.d : mk_v.n;
        my         = g_x;
      end
      ST_MUL: begin
        mctl.start = 1'b1;
        mctl.mode  = MDU_MUL;
        mx         = (mul_idx == 2'd0) ? a_v.n : a_v.d;
        case (mul_idx)
          2'd0:    my = cls_mul ? b_v.n : b_v.d;
          2'd1:    my = b_v.n;
          default: my = b_v.d;
        endcase
      end
      ST_COMB: begin
        mctl.start = (op_q == OP_REM);
        mx         = t1;
        my         = t2;
      end
      default: mctl.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          op_q <= op_t'(op);
          mk_v <= norm_in(a_num, a_den, a_eps);
          b_v  <= norm_in(b_num, b_den, b_eps);
          sel  <= SEL_A;
        end
      end
      ST_MK_CHK: begin
        if (is_zr(mk_v)) mk_v <= is_inf(mk_v) ? v_amb() : v_zero(mk_v.eps);
        else if (is_inf(mk_v)) mk_v <= v_inf(mk_v.neg ? S_NEG : S_POS);
        else begin
          g_x      <= mk_v.n;
          g_y      <= mk_v.d;
          mk_v.eps <= S_ZERO;
          quo_idx  <= 1'b0;
        end
      end
      ST_GCD_W: begin
        if (mdone) begin
          g_x <= g_y;
          g_y <= mrem;
        end
      end
      ST_QUO_W: begin
        if (mdone) begin
          if (quo_idx) mk_v.d <= mquo;
          else mk_v.n <= mquo;
          quo_idx <= 1'b1;
        end
      end
      ST_MK_END: begin
        case (sel)
          SEL_A: begin
            a_v  <= mk_v;
            mk_v <= b_v;
            sel  <= SEL_B;
          end
          SEL_B:   b_v <= mk_v;
          default: r_v <= mk_v;
        endcase
      end
      ST_B_XF: begin
        if (op_q == OP_SUB) b_v <= v_neg(b_v);
        else if (op_q == OP_DIV) b_v <= v_inv(b_v);
      end
      ST_DISP: begin
        r_v     <= sp_val;
        res_ord <= (op_q == OP_CMP) ? sp_ord : ORD_LT;
        res_eq  <= (op_q == OP_CMP) && sp_eq;
        res_err <= sp_err;
        mul_idx <= 2'd0;
        sel     <= SEL_R;
      end
      ST_MUL_W: begin
        if (mdone) begin
          case (mul_idx)
            2'd0:    t1 <= mquo;
            2'd1:    t2 <= mquo;
            default: t3 <= mquo;
          endcase
          mul_idx <= mul_idx + 1'b1;
        end
      end
      ST_COMB: begin
        mk_v.eps <= S_ZERO;
        mk_v.d   <= t3;
        if (cls_add) begin
          mk_v.n   <= sum_n;
          mk_v.neg <= sum_neg;
        end else begin
          mk_v.n   <= t1;
          mk_v.neg <= a_v.neg ^ b_v.neg;
        end
        res_ord <= (op_q == OP_CMP) ? cmp_ord : ORD_LT;
      end
      ST_REM_W: begin
        if (mdone) begin
          mk_v.n   <= mrem;
          mk_v.neg <= a_v.neg;
        end
      end
      default: ;
    endcase
  end

  // result packing
  logic ovf;
  assign ovf = !is_zr(r_v) && !is_inf(r_v) &&
               ((r_v.n > (r_v.neg ? LIM : LIM - 1'b1)) || (r_v.d > LIM - 1'b1));

  always_comb begin
    r_num    = '0;
    r_den    = '0;
    r_eps    = S_ZERO;
    overflow = 1'b0;
    if (op_q != OP_CMP && !is_amb(r_v)) begin
      if (is_inf(r_v)) r_num = r_v.neg ? '1 : 64'sd1;
      else if (is_zr(r_v)) begin
        r_den = 63'd1;
        r_eps = r_v.eps;
      end else if (ovf) overflow = 1'b1;
      else begin
        r_num = r_v.neg ? -64'(r_v.n) : 64'(r_v.n);
        r_den = 63'(r_v.d);
      end
    end
  end

  assign order = res_ord;
  assign equal = res_eq;
  assign error = res_err;
  assign busy  = (state != ST_IDLE);
  assign valid = (state == ST_DONE);

`ifndef NO_ASSERTIONS
  a_one_beat: assert property (@(posedge clk) disable iff (rst) valid |=> !busy)
    else $error("result beat longer than one cycle");
  a_accept: assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("accepted beat did not raise busy");
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
      valid && overflow |-> r_num == '0 && r_den == '0 && !error)
    else $error("overflow result not 0/0");
  a_err_amb: assert property (@(posedge clk) disable iff (rst)
      valid && error |-> r_den == '0 && order == ORD_LT && !equal)
    else $error("remainder error result not 0/0");
`endif

endmodule

FILE: sv/era_mdu.sv
// Shared iterative unit: shift-add multiplier and restoring divider.
module era_mdu import era_pkg::*; #(
  parameter int PW = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  mdu_ctl_t      ctl,
  input  logic [PW-1:0] x,
  input  logic [PW-1:0] y,
  output logic          done,
  output logic [PW-1:0] quo,
  output logic [PW-1:0] rem
);

  localparam int HW = PW / 2;
  localparam int CW = $clog2(PW + 1);

  logic          busy;
  mdu_mode_t     mode;
  logic [CW-1:0] cnt;
  logic [PW-1:0] acc;   // product, or dividend shifting into quotient
  logic [PW-1:0] opb;   // multiplicand, or divisor
  logic [PW-1:0] rr;    // multiplier, or partial remainder

  logic [PW:0]   sh;
  logic [PW:0]   diff;
  logic          ge;

  assign sh   = {rr, acc[PW-1]};
  assign diff = sh - {1'b0, opb};
  assign ge   = sh >= {1'b0, opb};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start && !busy) begin
        busy <= 1'b1;
        mode <= ctl.mode;
        if (ctl.mode == MDU_MUL) begin
          acc <= '0;
          opb <= {{HW{1'b0}}, x[HW-1:0]};
          rr  <= {{HW{1'b0}}, y[HW-1:0]};
          cnt <= CW'(HW);
        end else begin
          acc <= x;
          opb <= y;
          rr  <= '0;
          cnt <= CW'(PW);
        end
      end else if (busy) begin
        if (mode == MDU_MUL) begin
          if (rr[0]) acc <= acc + opb;
          opb <= {opb[PW-2:0], 1'b0};
          rr  <= {1'b0, rr[PW-1:1]};
        end else begin
          rr  <= ge ? diff[PW-1:0] : sh[PW-1:0];
          acc <= {acc[PW-2:0], ge};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = acc;
  assign rem = rr;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("mdu done while busy");
  a_busy_cnt: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("mdu busy with empty count");
  a_no_restart: assert property (@(posedge clk) disable iff (rst) ctl.start |-> !busy)
    else $error("mdu started while busy");
  a_rose: assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> $past(ctl.start))
    else $error("mdu busy without start");
`endif

endmodule
